[sv/icr_pkg.sv]
// Package: shared types, codes and constants of the impulse collision resolver.
`default_nettype none
package icr_pkg;

  localparam int unsigned VEL_W   = 32;
  localparam int unsigned MASS_W  = 32;
  localparam int unsigned REST_W  = 17;
  localparam int unsigned IDX_IN_W = 8;
  localparam logic [REST_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_NONE    = 2'd3
  } icr_op_t;

  typedef struct packed {
    logic        [1:0]          operation;
    logic        [IDX_IN_W-1:0] first_body;
    logic        [IDX_IN_W-1:0] second_body;
    logic signed [VEL_W-1:0]    normal_x;
    logic signed [VEL_W-1:0]    normal_y;
    logic signed [VEL_W-1:0]    normal_z;
    logic signed [VEL_W-1:0]    write_velocity_x;
    logic signed [VEL_W-1:0]    write_velocity_y;
    logic signed [VEL_W-1:0]    write_velocity_z;
    logic        [MASS_W-1:0]   write_mass;
    logic        [REST_W-1:0]   write_restitution;
  } icr_req_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] read_velocity_x;
    logic signed [VEL_W-1:0] read_velocity_y;
    logic signed [VEL_W-1:0] read_velocity_z;
    logic                    impulse_applied;
  } icr_rsp_t;

  typedef struct packed {
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
    logic signed [VEL_W-1:0]  vz;
    logic        [MASS_W-1:0] mass;
    logic        [REST_W-1:0] rest;
  } icr_body_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_WRITE_BODY,
    DP_READ_A,
    DP_READ_B,
    DP_LATCH_A,
    DP_LATCH_B,
    DP_DOT_LOAD,
    DP_DOT_ACC,
    DP_VN,
    DP_S_LOAD,
    DP_S_CAP,
    DP_K_LOAD,
    DP_DIV_START,
    DP_K_CAP,
    DP_D_LOAD,
    DP_D_APPLY,
    DP_WRITE_V1,
    DP_WRITE_V2,
    DP_OUT
  } icr_dp_op_t;

  typedef struct packed {
    icr_dp_op_t  op;
    logic [1:0]  lane;
    logic        sel;
  } icr_cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       separating;
    logic       div_busy;
  } icr_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_RD_A,
    ST_LAT_A,
    ST_RD_B,
    ST_LAT_B,
    ST_DOT_LOAD,
    ST_DOT_PROD,
    ST_DOT_ACC,
    ST_VN,
    ST_CHECK,
    ST_S_LOAD,
    ST_S_PROD,
    ST_S_CAP,
    ST_K_LOAD,
    ST_K_PROD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_K_CAP,
    ST_D_LOAD,
    ST_D_PROD,
    ST_D_APPLY,
    ST_WR_V1,
    ST_RD_B2,
    ST_LAT_B2,
    ST_WR_V2,
    ST_DONE
  } icr_state_t;

endpackage
`default_nettype wire

[sv/icr_divider.sv]
// Restoring divider: 65-bit dividend by 33-bit divisor, 33-bit quotient, one bit per cycle.
`default_nettype none
module icr_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [64:0] dividend,
  input  logic [32:0] divisor,
  output logic        busy,
  output logic [32:0] quotient
);
  logic [32:0] rem;
  logic [32:0] low;
  logic [32:0] dvs;
  logic [5:0]  cnt;
  logic [33:0] trial;
  logic        fits;

  // caller guarantees dividend < divisor * 2^33, so the top half starts below divisor
  assign trial = {rem, low[32]};
  assign fits  = trial >= {1'b0, dvs};
  assign busy  = cnt != 6'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= 6'd33;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend[64:33]};
      low      <= dividend[32:0];
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? 33'(trial - {1'b0, dvs}) : trial[32:0];
      low      <= {low[31:0], 1'b0};
      quotient <= {quotient[31:0], fits};
    end
  end
endmodule
`default_nettype wire

[sv/icr_datapath.sv]
// Datapath: body table, shared multiplier, divider and the velocity update registers.
`default_nettype none
module icr_datapath #(
  parameter int BODY_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  icr_pkg::icr_req_t   req,
  input  icr_pkg::icr_cmd_t   cmd,
  output icr_pkg::icr_status_t status,
  output icr_pkg::icr_rsp_t   rsp
);
  import icr_pkg::*;

  localparam int IDX_W = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
  typedef logic [IDX_W-1:0] idx_t;
  typedef idx_t wrap_tab_t [256];

  function automatic wrap_tab_t build_wrap();
    wrap_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = idx_t'(i % BODY_COUNT);
    end
    return t;
  endfunction

  localparam wrap_tab_t WRAP = build_wrap();

  function automatic logic [32:0] mag32(logic signed [31:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    return v[31] ? 33'(-e) : 33'(e);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  icr_body_t mem [BODY_COUNT];
  icr_body_t rd_body;
  icr_body_t wr_body;
  idx_t      wr_addr;
  logic      mem_we;

  logic [1:0]         op_r;
  idx_t               a_idx, b_idx;
  logic signed [31:0] n [3];
  logic signed [31:0] wv [3];
  logic [31:0]        wm;
  logic [16:0]        wr;
  logic signed [31:0] v1 [3];
  logic signed [31:0] v2 [3];
  logic [31:0]        m1, m2;
  logic [16:0]        e1, e2;
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod;
  logic signed [49:0] acc;
  logic signed [31:0] vn;
  logic               sep;
  logic [32:0]        s, sum, k1, k2;

  logic signed [31:0] n_l, rv_l;
  logic signed [32:0] diff_l;
  logic signed [49:0] term, delta;
  logic [16:0]        emin;
  logic               div_busy;
  logic [32:0]        quotient;

  assign n_l    = n[cmd.lane];
  assign diff_l = 33'(v2[cmd.lane]) - 33'(v1[cmd.lane]);
  assign rv_l   = sat32(50'(diff_l));
  assign term   = rv_l[31] ^ n_l[31] ? -$signed({2'b00, prod[63:16]})
                                     :  $signed({2'b00, prod[63:16]});
  assign delta  = n_l[31] ? -$signed({2'b00, prod[63:16]}) : $signed({2'b00, prod[63:16]});
  assign emin   = (e1 < e2) ? e1 : e2;

  assign mem_we  = cmd.op == DP_WRITE_BODY || cmd.op == DP_WRITE_V1 || cmd.op == DP_WRITE_V2;
  assign wr_addr = (cmd.op == DP_WRITE_V2) ? b_idx : a_idx;

  always_comb begin
    case (cmd.op)
      DP_WRITE_BODY: begin
        wr_body.vx   = wv[0];
        wr_body.vy   = wv[1];
        wr_body.vz   = wv[2];
        wr_body.mass = (wm == '0) ? 32'd1 : wm;
        wr_body.rest = (wr > ONE_Q16) ? ONE_Q16 : wr;
      end
      DP_WRITE_V2: begin
        wr_body = '{vx: v2[0], vy: v2[1], vz: v2[2], mass: m2, rest: e2};
      end
      default: begin
        wr_body = '{vx: v1[0], vy: v1[1], vz: v1[2], mass: m1, rest: e1};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_body;
    end
    if (cmd.op == DP_READ_A || cmd.op == DP_READ_B) begin
      rd_body <= mem[(cmd.op == DP_READ_B) ? b_idx : a_idx];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      DP_CAPTURE: begin
        op_r  <= req.operation;
        a_idx <= WRAP[req.first_body];
        b_idx <= WRAP[req.second_body];
        n[0]  <= req.normal_x;
        n[1]  <= req.normal_y;
        n[2]  <= req.normal_z;
        wv[0] <= req.write_velocity_x;
        wv[1] <= req.write_velocity_y;
        wv[2] <= req.write_velocity_z;
        wm    <= req.write_mass;
        wr    <= req.write_restitution;
      end
      DP_LATCH_A: begin
        v1[0] <= rd_body.vx;
        v1[1] <= rd_body.vy;
        v1[2] <= rd_body.vz;
        m1    <= rd_body.mass;
        e1    <= rd_body.rest;
      end
      DP_LATCH_B: begin
        v2[0] <= rd_body.vx;
        v2[1] <= rd_body.vy;
        v2[2] <= rd_body.vz;
        m2    <= rd_body.mass;
        e2    <= rd_body.rest;
        acc   <= '0;
      end
      DP_DOT_LOAD: begin
        mul_a <= mag32(rv_l);
        mul_b <= mag32(n_l);
      end
      DP_DOT_ACC: acc <= acc + term;
      DP_VN: begin
        vn  <= sat32(acc);
        sep <= acc > 50'sd0;
      end
      DP_S_LOAD: begin
        mul_a <= 33'(-(33'(vn)));
        mul_b <= 33'({1'b0, ONE_Q16} + {1'b0, emin});
      end
      DP_S_CAP: begin
        s   <= prod[48:16];
        sum <= 33'(m1) + 33'(m2);
      end
      DP_K_LOAD: begin
        mul_a <= s;
        mul_b <= cmd.sel ? 33'(m1) : 33'(m2);
      end
      DP_K_CAP: begin
        if (cmd.sel) k2 <= quotient;
        else         k1 <= quotient;
      end
      DP_D_LOAD: begin
        mul_a <= cmd.sel ? k2 : k1;
        mul_b <= mag32(n_l);
      end
      DP_D_APPLY: begin
        if (cmd.sel) v2[cmd.lane] <= sat32(50'(v2[cmd.lane]) + delta);
        else         v1[cmd.lane] <= sat32(50'(v1[cmd.lane]) - delta);
      end
      DP_OUT: begin
        rsp.read_velocity_x <= (op_r == OP_READ) ? v1[0] : '0;
        rsp.read_velocity_y <= (op_r == OP_READ) ? v1[1] : '0;
        rsp.read_velocity_z <= (op_r == OP_READ) ? v1[2] : '0;
        rsp.impulse_applied <= (op_r == OP_RESOLVE) && !sep;
      end
      default: ;
    endcase
  end

  icr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == DP_DIV_START),
    .dividend (prod[64:0]),
    .divisor  (sum),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign status = '{operation: op_r, separating: sep, div_busy: div_busy};
endmodule
`default_nettype wire

[sv/icr_controller.sv]
// Controller: sequences one operation through the datapath and owns both handshakes.
`default_nettype none
module icr_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  icr_pkg::icr_status_t status,
  output icr_pkg::icr_cmd_t    cmd
);
  import icr_pkg::*;

  icr_state_t state, state_next;
  logic [1:0] lane, lane_next;
  logic       sel, sel_next;
  logic       out_go;

  assign out_go = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lane      <= '0;
      sel       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
      sel   <= sel_next;
      if (out_go)         rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    lane_next  = lane;
    sel_next   = sel;
    case (state)
      ST_IDLE:     if (req_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (status.operation)
          OP_WRITE:   state_next = ST_WRITE;
          OP_READ:    state_next = ST_RD_A;
          OP_RESOLVE: state_next = ST_RD_A;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_WRITE:    state_next = ST_DONE;
      ST_RD_A:     state_next = ST_LAT_A;
      ST_LAT_A:    state_next = (status.operation == OP_READ) ? ST_DONE : ST_RD_B;
      ST_RD_B:     state_next = ST_LAT_B;
      ST_LAT_B: begin
        state_next = ST_DOT_LOAD;
        lane_next  = '0;
      end
      ST_DOT_LOAD: state_next = ST_DOT_PROD;
      ST_DOT_PROD: state_next = ST_DOT_ACC;
      ST_DOT_ACC: begin
        if (lane == 2'd2) begin
          state_next = ST_VN;
        end else begin
          state_next = ST_DOT_LOAD;
          lane_next  = lane + 2'd1;
        end
      end
      ST_VN:       state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = status.separating ? ST_DONE : ST_S_LOAD;
        sel_next   = 1'b0;
      end
      ST_S_LOAD:   state_next = ST_S_PROD;
      ST_S_PROD:   state_next = ST_S_CAP;
      ST_S_CAP:    state_next = ST_K_LOAD;
      ST_K_LOAD:   state_next = ST_K_PROD;
      ST_K_PROD:   state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!status.div_busy) state_next = ST_K_CAP;
      ST_K_CAP: begin
        if (!sel) begin
          state_next = ST_K_LOAD;
          sel_next   = 1'b1;
        end else begin
          state_next = ST_D_LOAD;
          sel_next   = 1'b0;
          lane_next  = '0;
        end
      end
      ST_D_LOAD:   state_next = ST_D_PROD;
      ST_D_PROD:   state_next = ST_D_APPLY;
      ST_D_APPLY: begin
        if (lane == 2'd2) begin
          state_next = sel ? ST_WR_V2 : ST_WR_V1;
        end else begin
          state_next = ST_D_LOAD;
          lane_next  = lane + 2'd1;
        end
      end
      ST_WR_V1: begin
        state_next = ST_RD_B2;
        sel_next   = 1'b1;
      end
      ST_RD_B2:    state_next = ST_LAT_B2;
      ST_LAT_B2: begin
        state_next = ST_D_LOAD;
        lane_next  = '0;
      end
      ST_WR_V2:    state_next = ST_DONE;
      ST_DONE:     if (out_go) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = state == ST_IDLE;
    cmd.lane  = lane;
    cmd.sel   = sel;
    case (state)
      ST_IDLE:      cmd.op = req_valid ? DP_CAPTURE : DP_NOP;
      ST_WRITE:     cmd.op = DP_WRITE_BODY;
      ST_RD_A:      cmd.op = DP_READ_A;
      ST_LAT_A:     cmd.op = DP_LATCH_A;
      ST_RD_B:      cmd.op = DP_READ_B;
      ST_LAT_B:     cmd.op = DP_LATCH_B;
      ST_DOT_LOAD:  cmd.op = DP_DOT_LOAD;
      ST_DOT_ACC:   cmd.op = DP_DOT_ACC;
      ST_VN:        cmd.op = DP_VN;
      ST_S_LOAD:    cmd.op = DP_S_LOAD;
      ST_S_CAP:     cmd.op = DP_S_CAP;
      ST_K_LOAD:    cmd.op = DP_K_LOAD;
      ST_DIV_START: cmd.op = DP_DIV_START;
      ST_K_CAP:     cmd.op = DP_K_CAP;
      ST_D_LOAD:    cmd.op = DP_D_LOAD;
      ST_D_APPLY:   cmd.op = DP_D_APPLY;
      ST_WR_V1:     cmd.op = DP_WRITE_V1;
      ST_RD_B2:     cmd.op = DP_READ_B;
      ST_LAT_B2:    cmd.op = DP_LATCH_B;
      ST_WR_V2:     cmd.op = DP_WRITE_V2;
      ST_DONE:      cmd.op = out_go ? DP_OUT : DP_NOP;
      default:      cmd.op = DP_NOP;
    endcase
  end
endmodule
`default_nettype wire

[sv/impulse_collision_resolver.sv]
// A full resolve makes two divider passes plus twelve multiply steps.
// Flow: one item at a time; the next req transfer can come in the cycle after the result is
//   loaded; a waiting result stalls only the next item's result load.
// Reset: synchronous, active high; clears the controller, divider count and output valid only.
//   The body table is not cleared; entries hold garbage until written.
`default_nettype none
module impulse_collision_resolver #(
  parameter int BODY_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  icr_pkg::icr_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output icr_pkg::icr_rsp_t rsp
);
  import icr_pkg::*;

  // controller only sees status; all arithmetic and the table sit in the datapath
  icr_cmd_t    cmd;
  icr_status_t status;

  // Sequencer: one state per micro-step. Multiplies go load, product, use;
  // the two impulse scales (j/m1, j/m2) each take one divider pass.
  icr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: body table (single port, registered read), one 33x33 multiplier
  // with registered product, signed dot accumulator and saturating updates.
  // Body one is written back before body two is re-read, so a collision of a
  // body with itself sees the first update.
  icr_datapath #(
    .BODY_COUNT (BODY_COUNT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );
endmodule
`default_nettype wire

[sv/icr_checker.sv]
// Checker: port-level properties of the resolver, bound to the top level.
`default_nettype none
module icr_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input icr_pkg::icr_rsp_t rsp
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req taken while busy");

  a_impulse_no_vel: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.impulse_applied |->
      rsp.read_velocity_x == 0 && rsp.read_velocity_y == 0 && rsp.read_velocity_z == 0)
    else $error("resolve result carries velocity");
endmodule

bind impulse_collision_resolver icr_checker u_chk (.*);
`default_nettype wire

[tb/impulse_collision_resolver_test.sv]
// Testbench: body-table impulse resolver checked against a bit-accurate collision predictor.
`timescale 1ns / 100ps
`default_nettype none

class collision_scoreboard;
  logic signed [31:0] vel_x [256];
  logic signed [31:0] vel_y [256];
  logic signed [31:0] vel_z [256];
  logic [31:0] mass_tab [256];
  logic [16:0] rest_tab [256];
  icr_pkg::icr_rsp_t pending_rsp [$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // k * |n| >> 16, signed like n (truncation toward zero)
  static function longint push_amount(longint unsigned k, longint n);
    longint unsigned mag;
    longint unsigned d;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    d = (k * mag) >> 16;
    return (n < 0) ? -longint'(d) : longint'(d);
  endfunction

  function void note_transfer(icr_pkg::icr_req_t r);
    icr_pkg::icr_rsp_t o;
    int a, b;
    longint rx, ry, rz, nx, ny, nz, vn;
    longint unsigned m1, m2, e, w, s, k1, k2;
    o = '0;
    a = r.first_body;
    b = r.second_body;
    nx = longint'(r.normal_x);
    ny = longint'(r.normal_y);
    nz = longint'(r.normal_z);
    case (icr_pkg::icr_op_t'(r.operation))
      icr_pkg::OP_WRITE: begin
        vel_x[a] = r.write_velocity_x;
        vel_y[a] = r.write_velocity_y;
        vel_z[a] = r.write_velocity_z;
        mass_tab[a] = (r.write_mass == 0) ? 32'd1 : r.write_mass;
        rest_tab[a] = (r.write_restitution > icr_pkg::ONE_Q16) ? icr_pkg::ONE_Q16
                                                               : r.write_restitution;
      end
      icr_pkg::OP_READ: begin
        o.read_velocity_x = vel_x[a];
        o.read_velocity_y = vel_y[a];
        o.read_velocity_z = vel_z[a];
      end
      icr_pkg::OP_RESOLVE: begin
        rx = clamp32(longint'(vel_x[b]) - longint'(vel_x[a]));
        ry = clamp32(longint'(vel_y[b]) - longint'(vel_y[a]));
        rz = clamp32(longint'(vel_z[b]) - longint'(vel_z[a]));
        // SV '/' on signed truncates toward zero
        vn = clamp32(rx * nx / 65536 + ry * ny / 65536 + rz * nz / 65536);
        if (vn <= 0) begin
          m1 = mass_tab[a];
          m2 = mass_tab[b];
          e = (rest_tab[a] < rest_tab[b]) ? rest_tab[a] : rest_tab[b];
          w = longint'(-vn);
          s = (w * (65536 + e)) >> 16;
          k1 = (s * m2) / (m1 + m2);
          k2 = (s * m1) / (m1 + m2);
          vel_x[a] = clamp32(longint'(vel_x[a]) - push_amount(k1, nx));
          vel_y[a] = clamp32(longint'(vel_y[a]) - push_amount(k1, ny));
          vel_z[a] = clamp32(longint'(vel_z[a]) - push_amount(k1, nz));
          vel_x[b] = clamp32(longint'(vel_x[b]) + push_amount(k2, nx));
          vel_y[b] = clamp32(longint'(vel_y[b]) + push_amount(k2, ny));
          vel_z[b] = clamp32(longint'(vel_z[b]) + push_amount(k2, nz));
          o.impulse_applied = 1'b1;
        end
      end
      default: ;
    endcase
    pending_rsp.push_back(o);
  endfunction

  function void check_result(icr_pkg::icr_rsp_t got);
    icr_pkg::icr_rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("unexpected result transfer %h", got);
      errors++;
      return;
    end
    want = pending_rsp.pop_front();
    if (got.read_velocity_x !== want.read_velocity_x) begin
      $error("read_velocity_x exp %h got %h", want.read_velocity_x, got.read_velocity_x);
      errors++;
    end
    if (got.read_velocity_y !== want.read_velocity_y) begin
      $error("read_velocity_y exp %h got %h", want.read_velocity_y, got.read_velocity_y);
      errors++;
    end
    if (got.read_velocity_z !== want.read_velocity_z) begin
      $error("read_velocity_z exp %h got %h", want.read_velocity_z, got.read_velocity_z);
      errors++;
    end
    if (got.impulse_applied !== want.impulse_applied) begin
      $error("impulse_applied exp %b got %b", want.impulse_applied, got.impulse_applied);
      errors++;
    end
  endfunction
endclass

module impulse_collision_resolver_test;
  import icr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  icr_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  icr_rsp_t rsp;

  collision_scoreboard sb = new();
  bit written [256];        // bodies that hold a defined entry
  bit send_done = 1'b0;
  bit stall_long = 1'b0;    // sender raises this to ask for one long receiver hold-off
  int signed n_boundary [8] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000,
                                32'shFFFF0000, 0, 1, -1, 32'sh00008000};

  always #10 clk = ~clk;

  impulse_collision_resolver u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // Offer one item after a random gap; hold it until the transfer.
  // Valid drops only when a gap follows, so back-to-back items keep it high.
  task automatic send_item(icr_req_t r, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_transfer(r);
    if (r.operation == OP_WRITE) written[r.first_body] = 1'b1;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return n_boundary[$urandom_range(0, 7)];
      1: return $urandom_range(0, 131072) - 65536;        // around unit size
      2: return $urandom_range(0, 4194304) - 2097152;     // a few tens of units
      default: return $urandom();
    endcase
  endfunction

  function automatic icr_req_t make_write(int idx);
    icr_req_t r;
    r = '0;
    r.operation = OP_WRITE;
    r.first_body = idx;
    r.second_body = $urandom();
    r.normal_x = $urandom();
    r.normal_y = $urandom();
    r.normal_z = $urandom();
    r.write_velocity_x = rand_word();
    r.write_velocity_y = rand_word();
    r.write_velocity_z = rand_word();
    case ($urandom_range(0, 4))
      0: r.write_mass = $urandom_range(0, 2);       // zero mass lands as one LSB
      1: r.write_mass = 32'hFFFFFFFF;
      2: r.write_mass = $urandom_range(16384, 1048576);
      default: r.write_mass = $urandom();
    endcase
    case ($urandom_range(0, 3))
      0: r.write_restitution = 17'h1FFFF - $urandom_range(0, 3); // saturates to 1.0
      1: r.write_restitution = ONE_Q16;
      default: r.write_restitution = $urandom_range(0, 65536);
    endcase
    return r;
  endfunction

  // Random index drawn among written bodies, mostly from a small cluster.
  function automatic int pick_written();
    int idx;
    do idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    while (!written[idx]);
    return idx;
  endfunction

  function automatic icr_req_t make_access(icr_op_t op);
    icr_req_t r;
    r = make_write(0);
    r.operation = op;
    r.first_body = pick_written();
    r.second_body = ($urandom_range(0, 9) == 0) ? r.first_body : pick_written();
    r.normal_x = rand_word();
    r.normal_y = rand_word();
    r.normal_z = rand_word();
    return r;
  endfunction

  initial begin : stimulus
    icr_req_t r;
    int pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of body index and values, every op, same body twice
    r = make_write(0);
    r.write_velocity_x = 32'sh7FFFFFFF; r.write_velocity_y = 32'sh80000000;
    r.write_velocity_z = 0; r.write_mass = 0; r.write_restitution = 17'h1FFFF;
    send_item(r, 1'b0);
    r = make_write(255);
    r.write_velocity_x = 32'sh80000000; r.write_velocity_y = 32'sh7FFFFFFF;
    r.write_velocity_z = -1; r.write_mass = 32'hFFFFFFFF; r.write_restitution = 0;
    send_item(r, 1'b0);
    r = make_write(1);
    r.write_velocity_x = 32'sh00010000; r.write_velocity_y = 0; r.write_velocity_z = 0;
    r.write_mass = 32'h00010000; r.write_restitution = ONE_Q16;
    send_item(r, 1'b0);
    r = make_access(OP_READ); r.first_body = 0; send_item(r, 1'b0);
    r = make_access(OP_READ); r.first_body = 255; send_item(r, 1'b0);
    // head-on: strong approach, saturating sums
    r = make_access(OP_RESOLVE); r.first_body = 0; r.second_body = 255;
    r.normal_x = 32'sh7FFFFFFF; r.normal_y = 32'sh80000000; r.normal_z = -1;
    send_item(r, 1'b0);
    // separating: 1 moves +x, 0 along x with normal -x
    r = make_access(OP_RESOLVE); r.first_body = 1; r.second_body = 0;
    r.normal_x = 32'shFFFF0000; r.normal_y = 0; r.normal_z = 0;
    send_item(r, 1'b0);
    // zero normal gives zero separating speed
    r = make_access(OP_RESOLVE); r.first_body = 1; r.second_body = 255;
    r.normal_x = 0; r.normal_y = 0; r.normal_z = 0;
    send_item(r, 1'b0);
    r = make_access(OP_RESOLVE); r.first_body = 1; r.second_body = 1;
    r.normal_x = 32'sh00010000;
    send_item(r, 1'b0);
    r = make_access(OP_NONE); r.first_body = 1; send_item(r, 1'b0);
    r = make_access(OP_READ); r.first_body = 1; send_item(r, 1'b0);
    r = make_access(OP_READ); r.first_body = 0; send_item(r, 1'b0);
    r = make_access(OP_READ); r.first_body = 255; send_item(r, 1'b0);

    // Random: mostly resolves, mixed with writes, reads and a few no-ops, over a small set of bodies
    for (int i = 0; i < 1900; i++) begin
      if (i == 600) stall_long = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 22) r = make_write(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                : $urandom_range(0, 15));
      else if (pick < 40) r = make_access(OP_READ);
      else if (pick < 96) r = make_access(OP_RESOLVE);
      else r = make_access(OP_NONE);
      send_item(r, (i >= 600 && i < 640) || (i % 200) > 180);
    end
    req_valid <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off while the sender keeps offering.
  // Ready drops only ahead of a wait, so back-to-back transfers keep it high.
  initial begin : drain
    int gap;
    @(negedge rst);
    forever begin
      if (stall_long) begin
        stall_long = 1'b0;
        rsp_ready <= 1'b0;
        repeat (2000) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      sb.check_result(rsp);
    end
  end

  initial begin : finish_up
    wait (send_done);
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("** impulse_collision_resolver: PASSED **");
    end else begin
      $display("** impulse_collision_resolver: FAILED **");
    end
    $finish;
  end

  // Slowest run: ~1920 items, each with the block's work plus a sender gap and a receiver stall, plus the hold-off.
  initial begin : watchdog
    #(20ns * 1500000);
    $display("** impulse_collision_resolver: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
